// ===== src/salc_pkg.sv =====
// ----------------------------------------------------------------------------
// salc_pkg
// shared constants and control types of the set associative cache with
// lru and lfu replacement
// ----------------------------------------------------------------------------
package salc_pkg;

  localparam int unsigned DefWays         = 8;
  localparam int unsigned DefMaxIndexBits = 6;
  localparam int unsigned DefAddrWidth    = 32;
  localparam int unsigned DefStampWidth   = 32;

  localparam int unsigned UsesWidth = 32;
  localparam int unsigned OutWidth  = 32;

  // configuration register indexes
  localparam logic [1:0] CfgOffsetBits = 2'd0;
  localparam logic [1:0] CfgIndexBits  = 2'd1;
  localparam logic [1:0] CfgWaysInUse  = 2'd2;
  localparam logic [1:0] CfgLfuMode    = 2'd3;

  // result status codes
  localparam logic [1:0] StatFill  = 2'd0;
  localparam logic [1:0] StatHit   = 2'd1;
  localparam logic [1:0] StatEvict = 2'd2;

  typedef struct packed {
    logic clr;
    logic accept;
    logic read;
    logic scan;
    logic write;
  } salc_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic scan_last;
    logic out_free;
  } salc_sts_t;

endpackage

// ===== src/salc_ctrl.sv =====
// ----------------------------------------------------------------------------
// salc_ctrl
// sequencer: clearing pass, then per request read, way scan and write back
// ----------------------------------------------------------------------------
module salc_ctrl
  import salc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  salc_sts_t sts_i,
  output salc_cmd_t cmd_o
);

  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StRead  = 3'd2;
  localparam logic [2:0] StScan  = 3'd3;
  localparam logic [2:0] StWrite = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StClear: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) state_d = StIdle;
      end
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = StRead;
        end
      end
      StRead: begin
        cmd_o.read = 1'b1;
        state_d    = StScan;
      end
      StScan: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) state_d = StWrite;
      end
      StWrite: begin
        if (sts_i.out_free) begin
          cmd_o.write = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign in_ready_o = (state_q == StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/salc_dp.sv =====
// ----------------------------------------------------------------------------
// salc_dp
// datapath: set memory, address split, way scan, line update and result
// register
// ----------------------------------------------------------------------------
module salc_dp
  import salc_pkg::*;
#(
  parameter int unsigned WAYS           = DefWays,
  parameter int unsigned MAX_INDEX_BITS = DefMaxIndexBits,
  parameter int unsigned ADDR_WIDTH     = DefAddrWidth,
  parameter int unsigned STAMP_WIDTH    = DefStampWidth,
  localparam int unsigned WI = (WAYS > 1) ? $clog2(WAYS) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  salc_cmd_t           cmd_i,
  output salc_sts_t           sts_o,
  input  logic [3:0]          ob_i,
  input  logic [2:0]          ib_i,
  input  logic [WI-1:0]       nw_m1_i,
  input  logic                lfu_i,
  input  logic [OutWidth-1:0] address_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          status_o,
  output logic [OutWidth-1:0] fill_addr_o,
  output logic [OutWidth-1:0] evict_addr_o,
  output logic [OutWidth-1:0] hit_total_o,
  output logic [OutWidth-1:0] miss_total_o,
  output logic [OutWidth-1:0] eviction_total_o
);

  localparam int unsigned AW       = ADDR_WIDTH;
  localparam int unsigned SW       = STAMP_WIDTH;
  localparam int unsigned SETW     = (MAX_INDEX_BITS > 0) ? MAX_INDEX_BITS : 1;
  localparam int unsigned NUM_SETS = 1 << MAX_INDEX_BITS;

  typedef struct packed {
    logic                 v;
    logic [AW-1:0]        tag;
    logic [SW-1:0]        stamp;
    logic [UsesWidth-1:0] uses;
  } line_t;

  typedef struct packed {
    logic [SW-1:0]         clk;
    line_t [WAYS-1:0]      ln;
  } row_t;

  row_t mem_q [NUM_SETS];
  row_t rd_q;
  row_t row_new;

  logic [SETW-1:0] clr_q;
  logic [AW-1:0]   addr_in, shifted, tag_in;
  logic [SETW-1:0] set_in, set_q;
  logic [4:0]      sh;
  logic [AW-1:0]   tag_q, block_q;

  logic [WI-1:0]   w_q, hit_way_q, emp_way_q, best_q;
  logic            hit_q, emp_q;
  line_t           cur, best_ln;

  logic [SW-1:0]   clk_new;
  logic [WI-1:0]   slot;
  line_t           ln_new;
  logic [1:0]      status_d;
  logic [AW-1:0]   victim;
  logic [AW+OutWidth-1:0] ins_x, vic_x;

  logic                out_valid_q;
  logic [1:0]          status_q;
  logic [OutWidth-1:0] ins_q, vic_q, hits_q, miss_q, evs_q;

  // address split
  always_comb begin
    logic [AW+OutWidth-1:0] ext;
    ext     = {{AW{1'b0}}, address_i};
    addr_in = ext[AW-1:0];
    shifted = addr_in >> ob_i;
    sh      = 5'(ob_i) + 5'(ib_i);
    set_in  = shifted[SETW-1:0] & ~({SETW{1'b1}} << ib_i);
    tag_in  = addr_in >> sh;
  end

  assign cur     = rd_q.ln[w_q];
  assign best_ln = rd_q.ln[best_q];

  assign sts_o.clr_last  = (clr_q == SETW'(NUM_SETS - 1));
  assign sts_o.scan_last = (w_q == nw_m1_i);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // line update
  always_comb begin
    clk_new = (&rd_q.clk) ? rd_q.clk : rd_q.clk + 1'b1;
    ln_new  = '0;
    victim  = '0;
    if (hit_q) begin
      slot     = hit_way_q;
      status_d = StatHit;
      ln_new   = rd_q.ln[hit_way_q];
      if (lfu_i && !(&ln_new.uses)) ln_new.uses = ln_new.uses + 1'b1;
    end else begin
      ln_new.v    = 1'b1;
      ln_new.tag  = tag_q;
      ln_new.uses = UsesWidth'(1);
      if (emp_q) begin
        slot     = emp_way_q;
        status_d = StatFill;
      end else begin
        slot     = best_q;
        status_d = StatEvict;
        victim   = (best_ln.tag << sh) | (AW'(set_q) << ob_i);
      end
    end
    ln_new.stamp      = clk_new;
    row_new           = rd_q;
    row_new.clk       = clk_new;
    row_new.ln[slot]  = ln_new;
    ins_x             = {{OutWidth{1'b0}}, (hit_q ? '0 : block_q)};
    vic_x             = {{OutWidth{1'b0}}, victim};
  end

  // set memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) mem_q[clr_q] <= '0;
    else if (cmd_i.write) mem_q[set_q] <= row_new;
    if (cmd_i.read) rd_q <= mem_q[set_q];
  end

  // request capture and scan
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      set_q   <= set_in;
      tag_q   <= tag_in;
      block_q <= (addr_in >> ob_i) << ob_i;
    end
    if (cmd_i.read) begin
      w_q   <= '0;
      hit_q <= 1'b0;
      emp_q <= 1'b0;
    end else if (cmd_i.scan) begin
      w_q <= w_q + 1'b1;
      if (!hit_q && cur.v && cur.tag == tag_q) begin
        hit_q     <= 1'b1;
        hit_way_q <= w_q;
      end
      if (!emp_q && !cur.v) begin
        emp_q     <= 1'b1;
        emp_way_q <= w_q;
      end
      if (w_q == '0) begin
        best_q <= w_q;
      end else if (!lfu_i) begin
        if (cur.stamp < best_ln.stamp) best_q <= w_q;
      end else if (cur.uses < best_ln.uses ||
                   (cur.uses == best_ln.uses && cur.stamp < best_ln.stamp)) begin
        best_q <= w_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      hits_q      <= '0;
      miss_q      <= '0;
      evs_q       <= '0;
    end else begin
      if (cmd_i.clr) clr_q <= clr_q + 1'b1;
      if (cmd_i.write) begin
        out_valid_q <= 1'b1;
        if (hit_q) begin
          if (!(&hits_q)) hits_q <= hits_q + 1'b1;
        end else begin
          if (!(&miss_q)) miss_q <= miss_q + 1'b1;
          if (!emp_q && !(&evs_q)) evs_q <= evs_q + 1'b1;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      status_q <= status_d;
      ins_q    <= ins_x[OutWidth-1:0];
      vic_q    <= vic_x[OutWidth-1:0];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign fill_addr_o      = ins_q;
  assign evict_addr_o     = vic_q;
  assign hit_total_o      = hits_q;
  assign miss_total_o     = miss_q;
  assign eviction_total_o = evs_q;

endmodule

// ===== src/set_assoc_cache_lru_lfu.sv =====
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_lfu
// flow: each request is read, then scanned serially over the ways in use,
//   then written back; write back waits until the result register is free
// requests: a new request is taken only after the last one is written back
// reset: clears control and totals, then a clearing pass over all
//   2^MAX_INDEX_BITS sets of the set memory during which no request is taken
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_lfu
  import salc_pkg::*;
#(
  parameter int unsigned WAYS           = DefWays,
  parameter int unsigned MAX_INDEX_BITS = DefMaxIndexBits,
  parameter int unsigned ADDR_WIDTH     = DefAddrWidth,
  parameter int unsigned STAMP_WIDTH    = DefStampWidth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [3:0]          cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [OutWidth-1:0] address_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          status_o,
  output logic [OutWidth-1:0] fill_addr_o,
  output logic [OutWidth-1:0] evict_addr_o,
  output logic [OutWidth-1:0] hit_total_o,
  output logic [OutWidth-1:0] miss_total_o,
  output logic [OutWidth-1:0] eviction_total_o
);

  localparam int unsigned WI = (WAYS > 1) ? $clog2(WAYS) : 1;

  logic [3:0] ob_q, nw_q;
  logic [2:0] ib_q, ib_c;
  logic       lfu_q;
  logic [4:0] nw_c;
  logic [4:0] nw_m1;
  salc_cmd_t  cmd;
  salc_sts_t  sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ob_q  <= 4'd4;
      ib_q  <= 3'd4;
      nw_q  <= 4'd8;
      lfu_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgOffsetBits: ob_q  <= cfg_data_i;
        CfgIndexBits:  ib_q  <= cfg_data_i[2:0];
        CfgWaysInUse:  nw_q  <= cfg_data_i;
        CfgLfuMode:    lfu_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ib_c = (int'(ib_q) > MAX_INDEX_BITS) ? 3'(MAX_INDEX_BITS) : ib_q;
    if (nw_q == 4'd0) nw_c = 5'd1;
    else if (int'(nw_q) > WAYS) nw_c = 5'(WAYS);
    else nw_c = {1'b0, nw_q};
    nw_m1 = nw_c - 5'd1;
  end

  salc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  salc_dp #(
    .WAYS           (WAYS),
    .MAX_INDEX_BITS (MAX_INDEX_BITS),
    .ADDR_WIDTH     (ADDR_WIDTH),
    .STAMP_WIDTH    (STAMP_WIDTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .ob_i             (ob_q),
    .ib_i             (ib_c),
    .nw_m1_i          (nw_m1[WI-1:0]),
    .lfu_i            (lfu_q),
    .address_i        (address_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .fill_addr_o      (fill_addr_o),
    .evict_addr_o     (evict_addr_o),
    .hit_total_o      (hit_total_o),
    .miss_total_o     (miss_total_o),
    .eviction_total_o (eviction_total_o)
  );

endmodule
